@@ design/priority_command_deque_assert.svh @@
// Assertion macros shared by the queue modules.
`ifndef PRIORITY_COMMAND_DEQUE_ASSERT_SVH
`define PRIORITY_COMMAND_DEQUE_ASSERT_SVH

`ifndef SYNTHESIS
`define PCDQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pcdq assertion failed");
`define PCDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pcdq assertion failed");
`else
`define PCDQ_ASSERT(lbl, clk, rstn, prop)
`define PCDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ design/pcdq_pkg.sv @@
package pcdq_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned KindW   = 2;
  localparam int unsigned SlaveW  = 8;
  localparam int unsigned RegW    = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned LevelW  = 5;

  localparam logic [ActionW-1:0] ACT_PUSH_WRITE = 3'd0;
  localparam logic [ActionW-1:0] ACT_PUSH_READ  = 3'd1;
  localparam logic [ActionW-1:0] ACT_PUSH_BATCH = 3'd2;
  localparam logic [ActionW-1:0] ACT_POP        = 3'd3;
  localparam logic [ActionW-1:0] ACT_CLEAR      = 3'd4;

  localparam logic [KindW-1:0] KIND_WRITE = 2'd0;
  localparam logic [KindW-1:0] KIND_READ  = 2'd1;
  localparam logic [KindW-1:0] KIND_BATCH = 2'd2;

  localparam logic [CountW-1:0] COUNT_SINGLE = 8'd1;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [SlaveW-1:0] slave;
    logic [RegW-1:0]   reg_addr;
    logic [CountW-1:0] count;
    logic [ValueW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic ok;
  } op_t;

endpackage

@@ design/pcdq_if.sv @@
interface pcdq_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [pcdq_pkg::ActionW-1:0]    action;
  logic [pcdq_pkg::SlaveW-1:0]     target_id;
  logic [pcdq_pkg::RegW-1:0]       reg_addr;
  logic [pcdq_pkg::CountW-1:0]     reg_count;
  logic [pcdq_pkg::ValueW-1:0]     write_value;

  modport source (output valid, action, target_id, reg_addr, reg_count, write_value,
                  input ready);
  modport sink (input valid, action, target_id, reg_addr, reg_count, write_value,
                output ready);
endinterface

interface pcdq_res_if;
  logic                            valid;
  logic                            ready;
  logic                            accepted;
  logic [pcdq_pkg::KindW-1:0]      cmd_kind;
  logic [pcdq_pkg::SlaveW-1:0]     out_slave;
  logic [pcdq_pkg::RegW-1:0]       out_reg;
  logic [pcdq_pkg::CountW-1:0]     out_count;
  logic [pcdq_pkg::ValueW-1:0]     out_value;
  logic [pcdq_pkg::LevelW-1:0]     queue_level;

  modport source (output valid, accepted, cmd_kind, out_slave, out_reg, out_count,
                  out_value, queue_level, input ready);
  modport sink (input valid, accepted, cmd_kind, out_slave, out_reg, out_count,
                out_value, queue_level, output ready);
endinterface

@@ design/pcdq_ram.sv @@
module pcdq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  pcdq_pkg::entry_t    wr_data_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output pcdq_pkg::entry_t    rd_data_o
);

  pcdq_pkg::entry_t mem_q [DEPTH];
  pcdq_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/pcdq_ptr.sv @@
`include "priority_command_deque_assert.svh"

module pcdq_ptr #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned LW    = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic [pcdq_pkg::ActionW-1:0]  action_i,
  output pcdq_pkg::op_t                 op_o,
  output logic [AW-1:0]                 wr_addr_o,
  output logic [AW-1:0]                 rd_addr_o,
  output logic [LW-1:0]                 level_o
);

  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [LW-1:0] level_q, level_d;
  logic [AW-1:0] head_dec, head_inc, tail_inc;
  logic          full, empty;
  pcdq_pkg::op_t op;

  assign full     = (level_q == LW'(DEPTH));
  assign empty    = (level_q == '0);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    level_d   = level_q;
    op        = '0;
    wr_addr_o = tail_q;
    case (action_i)
      pcdq_pkg::ACT_PUSH_WRITE: begin
        if (!full) begin
          op.wr_en  = 1'b1;
          op.ok     = 1'b1;
          wr_addr_o = head_dec;
          head_d    = head_dec;
          level_d   = level_q + 1'b1;
        end
      end
      pcdq_pkg::ACT_PUSH_READ, pcdq_pkg::ACT_PUSH_BATCH: begin
        if (!full) begin
          op.wr_en = 1'b1;
          op.ok    = 1'b1;
          tail_d   = tail_inc;
          level_d  = level_q + 1'b1;
        end
      end
      pcdq_pkg::ACT_POP: begin
        if (!empty) begin
          op.rd_en = 1'b1;
          op.ok    = 1'b1;
          head_d   = head_inc;
          level_d  = level_q - 1'b1;
        end
      end
      pcdq_pkg::ACT_CLEAR: begin
        op.ok   = 1'b1;
        head_d  = '0;
        tail_d  = '0;
        level_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign op_o      = acc_i ? op : '0;
  assign rd_addr_o = head_q;
  assign level_o   = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      level_q <= '0;
    end else if (acc_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      level_q <= level_d;
    end
  end

  `PCDQ_ASSERT(a_level_bound, clk_i, rst_ni, level_q <= LW'(DEPTH))
  `PCDQ_ASSERT(a_empty_ptrs, clk_i, rst_ni, (level_q != '0) || (head_q == tail_q))
  `PCDQ_ASSERT_NEXT(a_clear, clk_i, rst_ni, acc_i && (action_i == pcdq_pkg::ACT_CLEAR), (level_q == '0) && (head_q == '0) && (tail_q == '0))

endmodule

@@ design/priority_command_deque.sv @@
// A taken command passes the s1 stage (registered memory read), then the output register.
// Throughput: one command per cycle unless results stall; a stalled result holds one
// command in the read stage. Only a stored push writes and only a delivered pop reads the
// entry memory, once each. Reset clears head, tail, level and both stage valid flags; entry
// contents stay undefined until written.
`include "priority_command_deque_assert.svh"

module priority_command_deque #(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcdq_cmd_if.sink   cmd_i,
  pcdq_res_if.source res_o
);

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW  = $clog2(DEPTH + 1);
  localparam int unsigned QLW = pcdq_pkg::LevelW;

  logic              in_ready, in_fire, s1_adv;
  pcdq_pkg::op_t     op;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [LW-1:0]     level_nxt;
  pcdq_pkg::entry_t  wr_entry, rd_entry;

  logic              s1_v_q, s1_pop_q, s1_ok_q;
  logic [LW-1:0]     s1_lvl_q;
  logic              out_v_q, out_ok_q;
  logic [LW-1:0]     out_lvl_q;
  pcdq_pkg::entry_t  out_entry_q;

  assign s1_adv   = !out_v_q || res_o.ready;
  assign in_ready = !s1_v_q || s1_adv;
  assign in_fire  = cmd_i.valid && in_ready;
  assign cmd_i.ready = in_ready;

  always_comb begin
    wr_entry.slave    = cmd_i.target_id;
    wr_entry.reg_addr = cmd_i.reg_addr;
    wr_entry.count    = pcdq_pkg::COUNT_SINGLE;
    wr_entry.value    = '0;
    wr_entry.kind     = pcdq_pkg::KIND_READ;
    case (cmd_i.action)
      pcdq_pkg::ACT_PUSH_WRITE: begin
        wr_entry.kind  = pcdq_pkg::KIND_WRITE;
        wr_entry.value = cmd_i.write_value;
      end
      pcdq_pkg::ACT_PUSH_BATCH: begin
        wr_entry.kind  = pcdq_pkg::KIND_BATCH;
        wr_entry.count = cmd_i.reg_count;
      end
      default: begin
      end
    endcase
  end

  pcdq_ptr #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .LW    (LW)
  ) u_ptr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (in_fire),
    .action_i  (cmd_i.action),
    .op_o      (op),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr),
    .level_o   (level_nxt)
  );

  pcdq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (op.wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_en_i   (op.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_v_q && s1_adv) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pop_q <= op.rd_en;
      s1_ok_q  <= op.ok;
      s1_lvl_q <= level_nxt;
    end
    if (s1_v_q && s1_adv) begin
      out_ok_q    <= s1_ok_q;
      out_lvl_q   <= s1_lvl_q;
      out_entry_q <= s1_pop_q ? rd_entry : '0;
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.accepted    = out_ok_q;
  assign res_o.cmd_kind    = out_entry_q.kind;
  assign res_o.out_slave   = out_entry_q.slave;
  assign res_o.out_reg     = out_entry_q.reg_addr;
  assign res_o.out_count   = out_entry_q.count;
  assign res_o.out_value   = out_entry_q.value;
  assign res_o.queue_level = QLW'(out_lvl_q);

  `PCDQ_ASSERT_NEXT(a_fire_fills_stage, clk_i, rst_ni, in_fire, s1_v_q)
  `PCDQ_ASSERT(a_refused_zero, clk_i, rst_ni, !out_v_q || out_ok_q || (out_entry_q == '0))
  `PCDQ_ASSERT_NEXT(a_stage_moves, clk_i, rst_ni, s1_v_q && s1_adv, out_v_q)

endmodule

@@ dv/priority_command_deque_test.sv @@
`timescale 1ns / 100ps

module priority_command_deque_test;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned IdxW     = $clog2(DEPTH);
  localparam int unsigned LvlW     = pcdq_pkg::LevelW;
  localparam int unsigned StallLen = 200;
  localparam int unsigned IdleMax  = 4000;
  localparam int unsigned ShowMax  = 10;

  localparam int unsigned ActW = pcdq_pkg::ActionW;
  localparam int unsigned SlvW = pcdq_pkg::SlaveW;
  localparam int unsigned AdrW = pcdq_pkg::RegW;
  localparam int unsigned CntW = pcdq_pkg::CountW;
  localparam int unsigned ValW = pcdq_pkg::ValueW;
  localparam int unsigned KndW = pcdq_pkg::KindW;

  localparam logic [ActW-1:0] ACT_UNUSED_FIRST = pcdq_pkg::ACT_CLEAR + 1'b1;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [SlvW-1:0] slave;
    logic [AdrW-1:0] reg_addr;
    logic [CntW-1:0] count;
    logic [ValW-1:0] value;
  } cmd_beat_t;

  typedef struct packed {
    logic            accepted;
    logic [KndW-1:0] kind;
    logic [SlvW-1:0] slave;
    logic [AdrW-1:0] reg_addr;
    logic [CntW-1:0] count;
    logic [ValW-1:0] value;
    logic [LvlW-1:0] level;
  } deque_result_t;

  logic clk_i;
  logic rst_ni;

  pcdq_cmd_if cmd_if ();
  pcdq_res_if res_if ();

  priority_command_deque #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  cmd_beat_t     pending_cmds[$];
  deque_result_t due_results[$];

  pcdq_pkg::entry_t slot_mem[DEPTH];
  logic [IdxW-1:0]  head_idx   = '0;
  logic [IdxW-1:0]  tail_idx   = '0;
  logic [LvlW-1:0]  fill_level = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned stall_left    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned mismatches    = 0;
  logic        cmd_taken     = 1'b0;

  function automatic deque_result_t predict_deque(cmd_beat_t b);
    deque_result_t    r;
    pcdq_pkg::entry_t e;
    r          = '0;
    e.kind     = pcdq_pkg::KIND_READ;
    e.slave    = b.slave;
    e.reg_addr = b.reg_addr;
    e.count    = pcdq_pkg::COUNT_SINGLE;
    e.value    = '0;
    case (b.action)
      pcdq_pkg::ACT_PUSH_WRITE: begin
        if (fill_level < DEPTH) begin
          e.kind             = pcdq_pkg::KIND_WRITE;
          e.value            = b.value;
          head_idx           = head_idx - 1'b1;
          slot_mem[head_idx] = e;
          fill_level         = fill_level + 1'b1;
          r.accepted         = 1'b1;
        end
      end
      pcdq_pkg::ACT_PUSH_READ, pcdq_pkg::ACT_PUSH_BATCH: begin
        if (fill_level < DEPTH) begin
          if (b.action == pcdq_pkg::ACT_PUSH_BATCH) begin
            e.kind  = pcdq_pkg::KIND_BATCH;
            e.count = b.count;
          end
          slot_mem[tail_idx] = e;
          tail_idx           = tail_idx + 1'b1;
          fill_level         = fill_level + 1'b1;
          r.accepted         = 1'b1;
        end
      end
      pcdq_pkg::ACT_POP: begin
        if (fill_level != 0) begin
          e          = slot_mem[head_idx];
          head_idx   = head_idx + 1'b1;
          fill_level = fill_level - 1'b1;
          r.accepted = 1'b1;
          r.kind     = e.kind;
          r.slave    = e.slave;
          r.reg_addr = e.reg_addr;
          r.count    = e.count;
          r.value    = e.value;
        end
      end
      pcdq_pkg::ACT_CLEAR: begin
        head_idx   = '0;
        tail_idx   = '0;
        fill_level = '0;
        r.accepted = 1'b1;
      end
      default: begin
      end
    endcase
    r.level = fill_level;
    return r;
  endfunction

  function automatic string show_result(deque_result_t r);
    return $sformatf("acc=%0d kind=%0d slave=%02h reg=%04h cnt=%02h val=%04h lvl=%0d",
                     r.accepted, r.kind, r.slave, r.reg_addr, r.count, r.value, r.level);
  endfunction

  task automatic report_fault(string msg);
    mismatches++;
    if (mismatches <= ShowMax) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic add_cmd(cmd_beat_t b);
    pending_cmds.insert(pending_cmds.size(), b);
  endtask

  function automatic cmd_beat_t make_beat(logic [ActW-1:0] act);
    cmd_beat_t b;
    b.action   = act;
    b.slave    = SlvW'($urandom);
    b.reg_addr = AdrW'($urandom);
    b.value    = ValW'($urandom);
    case ($urandom_range(7))
      0:       b.count = '0;
      1:       b.count = '1;
      default: b.count = CntW'($urandom);
    endcase
    return b;
  endfunction

  function automatic logic [ActW-1:0] pick_push();
    case ($urandom_range(2))
      0:       return pcdq_pkg::ACT_PUSH_WRITE;
      1:       return pcdq_pkg::ACT_PUSH_READ;
      default: return pcdq_pkg::ACT_PUSH_BATCH;
    endcase
  endfunction

  task automatic queue_random(int unsigned n);
    int unsigned          left;
    int unsigned          burst;
    int unsigned          push_pct;
    int unsigned          r;
    logic [ActW-1:0]      act;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(40, 8);
      case ($urandom_range(2))
        0:       push_pct = 80;
        1:       push_pct = 25;
        default: push_pct = 55;
      endcase
      for (int i = 0; i < burst && left > 0; i++) begin
        r = $urandom_range(99);
        if (r < 2) begin
          act = pcdq_pkg::ACT_CLEAR;
        end else if (r < 4) begin
          act = ACT_UNUSED_FIRST + ActW'($urandom_range(2));
        end else if (r < push_pct) begin
          act = pick_push();
        end else begin
          act = pcdq_pkg::ACT_POP;
        end
        add_cmd(make_beat(act));
        left--;
      end
    end
  endtask

  task automatic queue_directed();
    add_cmd('{pcdq_pkg::ACT_POP,        8'h00, 16'h0000, 8'h00, 16'h0000});
    add_cmd('{pcdq_pkg::ACT_PUSH_WRITE, 8'hff, 16'hffff, 8'hff, 16'hffff});
    add_cmd('{pcdq_pkg::ACT_PUSH_READ,  8'h00, 16'h0000, 8'hff, 16'hffff});
    add_cmd('{pcdq_pkg::ACT_PUSH_BATCH, 8'h5a, 16'h8001, 8'h00, 16'hffff});
    add_cmd('{pcdq_pkg::ACT_PUSH_BATCH, 8'haa, 16'h5555, 8'hff, 16'h0000});
    add_cmd('{pcdq_pkg::ACT_PUSH_WRITE, 8'h01, 16'h0001, 8'h00, 16'h0000});
    for (int i = 0; i < 3; i++) begin
      add_cmd(make_beat(ACT_UNUSED_FIRST + ActW'(i)));
    end
    repeat (6) add_cmd(make_beat(pcdq_pkg::ACT_POP));
    add_cmd('{pcdq_pkg::ACT_PUSH_READ,  8'h80, 16'h7fff, 8'h00, 16'h0000});
    add_cmd('{pcdq_pkg::ACT_PUSH_BATCH, 8'h7f, 16'h8000, 8'h80, 16'h0000});
    add_cmd(make_beat(pcdq_pkg::ACT_CLEAR));
    add_cmd(make_beat(pcdq_pkg::ACT_POP));
    add_cmd(make_beat(pcdq_pkg::ACT_PUSH_WRITE));
    add_cmd(make_beat(pcdq_pkg::ACT_POP));
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || cmd_if.valid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin : drive_cmd
    cmd_beat_t b;
    if (!cmd_if.valid || cmd_taken) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        b = pending_cmds[0];
        pending_cmds.delete(0);
        cmd_if.action        <= b.action;
        cmd_if.target_id     <= b.slave;
        cmd_if.reg_addr      <= b.reg_addr;
        cmd_if.reg_count     <= b.count;
        cmd_if.write_value   <= b.value;
        cmd_if.valid         <= 1'b1;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served  <= hold_requests;
      stall_left   <= StallLen;
      res_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : watch_results
    deque_result_t got;
    deque_result_t want;
    cmd_beat_t     b;
    cmd_taken <= cmd_if.valid && cmd_if.ready;
    if (res_if.valid && res_if.ready) begin
      got = '{res_if.accepted, res_if.cmd_kind, res_if.out_slave, res_if.out_reg,
              res_if.out_count, res_if.out_value, res_if.queue_level};
      if (due_results.size() == 0) begin
        report_fault({"result beat with nothing outstanding: ", show_result(got)});
      end else begin
        want = due_results[0];
        due_results.delete(0);
        if (got.accepted !== want.accepted || got.kind !== want.kind ||
            got.slave !== want.slave || got.reg_addr !== want.reg_addr ||
            got.count !== want.count || got.value !== want.value ||
            got.level !== want.level) begin
          report_fault({"want ", show_result(want), " got ", show_result(got)});
        end
      end
    end
    if (cmd_if.valid && cmd_if.ready) begin
      b = '{cmd_if.action, cmd_if.target_id, cmd_if.reg_addr, cmd_if.reg_count,
            cmd_if.write_value};
      due_results.insert(due_results.size(), predict_deque(b));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleMax) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.action      = pcdq_pkg::ACT_POP;
    cmd_if.target_id   = '0;
    cmd_if.reg_addr    = '0;
    cmd_if.reg_count   = '0;
    cmd_if.write_value = '0;
    res_if.ready       = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    send_idle_pct = 37;
    recv_idle_pct = 88;
    queue_directed();
    queue_random(380);
    drain();

    send_idle_pct = 88;
    recv_idle_pct = 37;
    queue_random(400);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // hold the result side while a run of pushes backs up the block
    hold_requests++;
    repeat (40) add_cmd(make_beat(pick_push()));
    queue_random(380);
    drain();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
